[rtl/uvs_pkg.sv]
package uvs_pkg;

	// Fixed field widths of the record stream.
	localparam int CNT_W = 6;
	localparam int IDX_W = 11;
	localparam int ANG_W = 32;
	localparam int TEX_W = 16;
	localparam int POS_W = 24;
	localparam int NRM_W = 16;
	localparam int SCL_W = 16;

	// Record kinds.
	localparam logic PHASE_VERTEX = 1'b0;
	localparam logic PHASE_INDEX  = 1'b1;

	// Rotation unit constants: angles in turns, 2^32 per turn, results in Q30.
	localparam int CORDIC_STEPS = 30;
	localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
	localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
		30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
		30'd20, 30'd10, 30'd5, 30'd3, 30'd1
	};

	// One job handed from the sequencer to the datapath.
	typedef struct packed {
		logic             phase;
		logic [ANG_W-1:0] angle_u;
		logic [ANG_W-1:0] angle_v;
		logic [TEX_W-1:0] tex_s;
		logic [TEX_W-1:0] tex_t;
		logic [IDX_W-1:0] index_value;
		logic             last;
	} job_t;

endpackage

[rtl/uv_sphere_mesh_generator.sv]
// UV sphere mesh stream generator.
// Input channel (in_valid/in_ready, restart): each transfer asks for one record;
// restart high rewinds to the north pole vertex before that record is made.
// Output channel (out_valid/out_ready): one record per input transfer, in order.
// Vertex records come first, stack by stack, then triangle corner indices, with
// last high on the final index; the stream then wraps to the first vertex.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// three Q8.8 scale registers; it is always ready and ignores unknown indexes.
// A sequencer classifies each input and queues a job in a two-entry queue; a
// datapath turns vertex jobs into positions, normals and texture coordinates.
// A vertex leaves the queue, runs through 30 rotation steps, then the multiply,
// rounding and output states before it reaches the output register. The datapath
// takes no new job while it works on a vertex; an index record goes straight to
// the output register. The input side keeps accepting while the queue has room.
// When the receiver stalls, the output register holds its record and the queue
// fills, after which in_ready drops. Reset empties the queue and the output
// register, rewinds to the first vertex and sets every scale to 1.0.
module uv_sphere_mesh_generator import uvs_pkg::*; #(
	parameter int SECTORS = 32,
	parameter int STACKS  = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    restart,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    phase,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic [TEX_W-1:0]        tex_s,
	output logic [TEX_W-1:0]        tex_t,
	output logic signed [NRM_W-1:0] norm_x,
	output logic signed [NRM_W-1:0] norm_y,
	output logic signed [NRM_W-1:0] norm_z,
	output logic [IDX_W-1:0]        index_value,
	output logic                    last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [SCL_W-1:0]        cfg_data
);

	localparam logic [1:0] CFG_SCALE_X = 2'd0;
	localparam logic [1:0] CFG_SCALE_Y = 2'd1;
	localparam logic [1:0] CFG_SCALE_Z = 2'd2;
	localparam logic [SCL_W-1:0] SCALE_ONE = SCL_W'(256);

	logic [SCL_W-1:0] scale_x_q, scale_y_q, scale_z_q;
	logic [SCL_W-1:0] max_xy, max_scale;
	logic             push_valid, push_ready, pop_valid, pop_ready;
	job_t             push_job, pop_job;

	assign cfg_ready = 1'b1;

	// Scale registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= SCALE_ONE;
			scale_y_q <= SCALE_ONE;
			scale_z_q <= SCALE_ONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCALE_X: scale_x_q <= cfg_data;
				CFG_SCALE_Y: scale_y_q <= cfg_data;
				CFG_SCALE_Z: scale_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The radius: the largest scale.
	always_comb begin
		max_xy    = (scale_y_q > scale_x_q) ? scale_y_q : scale_x_q;
		max_scale = (scale_z_q > max_xy) ? scale_z_q : max_xy;
	end

	uvs_front #(
		.SECTORS (SECTORS),
		.STACKS  (STACKS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	uvs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	uvs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_job     (pop_job),
		.max_scale   (max_scale),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.phase       (phase),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.tex_s       (tex_s),
		.tex_t       (tex_t),
		.norm_x      (norm_x),
		.norm_y      (norm_y),
		.norm_z      (norm_z),
		.index_value (index_value),
		.last        (last)
	);

endmodule

[rtl/uvs_front.sv]
module uvs_front import uvs_pkg::*; #(
	parameter int SECTORS = 32,
	parameter int STACKS  = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic restart,
	output logic push_valid,
	input  logic push_ready,
	output job_t push_job
);

	// Per-step increments of the rounded quotients, split into whole part and remainder.
	localparam logic [ANG_W-1:0] AU_QSTEP = ANG_W'((64'd1 << 31) / STACKS);
	localparam logic [CNT_W-1:0] AU_RSTEP = CNT_W'((64'd1 << 31) % STACKS);
	localparam logic [ANG_W-1:0] AV_QSTEP = ANG_W'((64'd1 << 32) / SECTORS);
	localparam logic [CNT_W-1:0] AV_RSTEP = CNT_W'((64'd1 << 32) % SECTORS);
	localparam logic [TEX_W-1:0] TS_QSTEP = TEX_W'(32768 / SECTORS);
	localparam logic [CNT_W-1:0] TS_RSTEP = CNT_W'(32768 % SECTORS);
	localparam logic [TEX_W-1:0] TT_QSTEP = TEX_W'(32768 / STACKS);
	localparam logic [CNT_W-1:0] TT_RSTEP = CNT_W'(32768 % STACKS);
	localparam logic [CNT_W-1:0] HALF_STK = CNT_W'(STACKS / 2);
	localparam logic [CNT_W-1:0] HALF_SEC = CNT_W'(SECTORS / 2);
	localparam logic [CNT_W:0]   STK_DIV  = (CNT_W+1)'(STACKS);
	localparam logic [CNT_W:0]   SEC_DIV  = (CNT_W+1)'(SECTORS);
	localparam logic [CNT_W-1:0] STK_MAX  = CNT_W'(STACKS);
	localparam logic [CNT_W-1:0] SEC_MAX  = CNT_W'(SECTORS);
	localparam logic [CNT_W-1:0] STK_LAST = CNT_W'(STACKS - 1);
	localparam logic [CNT_W-1:0] SEC_LAST = CNT_W'(SECTORS - 1);
	localparam int               K_W      = IDX_W + 2;
	localparam logic [K_W-1:0]   ROW_LEN  = K_W'(SECTORS + 1);

	// Corners of the two triangles of one sector quad.
	localparam logic [2:0] CORNER_A0 = 3'd0;
	localparam logic [2:0] CORNER_A1 = 3'd1;
	localparam logic [2:0] CORNER_A2 = 3'd2;
	localparam logic [2:0] CORNER_B0 = 3'd3;
	localparam logic [2:0] CORNER_B1 = 3'd4;
	localparam logic [2:0] CORNER_END = 3'd6;

	logic             phase_q;
	logic [CNT_W-1:0] stack_q, sector_q;
	logic [2:0]       corner_q;
	logic [ANG_W-1:0] au_q, av_q;
	logic [TEX_W-1:0] ts_q, tt_q;
	logic [CNT_W-1:0] au_r_q, av_r_q, ts_r_q, tt_r_q;

	logic             phase_c, phase_n;
	logic [CNT_W-1:0] stack_c, sector_c, stack_n, sector_n;
	logic [2:0]       corner_c, corner_e, corner_n;
	logic [ANG_W-1:0] au_c, av_c, au_n, av_n;
	logic [TEX_W-1:0] ts_c, tt_c, ts_n, tt_n;
	logic [CNT_W-1:0] au_r_c, av_r_c, ts_r_c, tt_r_c;
	logic [CNT_W-1:0] au_r_n, av_r_n, ts_r_n, tt_r_n;
	logic [CNT_W:0]   au_sum, av_sum, ts_sum, tt_sum;
	logic [K_W-1:0]   k1, k2, corner_val;
	logic             take;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign take       = in_valid && push_ready;

	// A rewind puts every counter and accumulator back to its start.
	always_comb begin
		if (restart) begin
			phase_c  = PHASE_VERTEX;
			stack_c  = '0;
			sector_c = '0;
			corner_c = '0;
			au_c     = '0;
			av_c     = '0;
			ts_c     = '0;
			tt_c     = '0;
			au_r_c   = HALF_STK;
			tt_r_c   = HALF_STK;
			av_r_c   = HALF_SEC;
			ts_r_c   = HALF_SEC;
		end else begin
			phase_c  = phase_q;
			stack_c  = stack_q;
			sector_c = sector_q;
			corner_c = corner_q;
			au_c     = au_q;
			av_c     = av_q;
			ts_c     = ts_q;
			tt_c     = tt_q;
			au_r_c   = au_r_q;
			tt_r_c   = tt_r_q;
			av_r_c   = av_r_q;
			ts_r_c   = ts_r_q;
		end
	end

	// Next values of the rounded quotients: add the step, fold the remainder once.
	always_comb begin
		au_sum = {1'b0, au_r_c} + {1'b0, AU_RSTEP};
		tt_sum = {1'b0, tt_r_c} + {1'b0, TT_RSTEP};
		av_sum = {1'b0, av_r_c} + {1'b0, AV_RSTEP};
		ts_sum = {1'b0, ts_r_c} + {1'b0, TS_RSTEP};
		if (au_sum >= STK_DIV) begin
			au_r_n = CNT_W'(au_sum - STK_DIV);
			au_n   = au_c + AU_QSTEP + ANG_W'(1);
		end else begin
			au_r_n = au_sum[CNT_W-1:0];
			au_n   = au_c + AU_QSTEP;
		end
		if (tt_sum >= STK_DIV) begin
			tt_r_n = CNT_W'(tt_sum - STK_DIV);
			tt_n   = tt_c + TT_QSTEP + TEX_W'(1);
		end else begin
			tt_r_n = tt_sum[CNT_W-1:0];
			tt_n   = tt_c + TT_QSTEP;
		end
		if (av_sum >= SEC_DIV) begin
			av_r_n = CNT_W'(av_sum - SEC_DIV);
			av_n   = av_c + AV_QSTEP + ANG_W'(1);
		end else begin
			av_r_n = av_sum[CNT_W-1:0];
			av_n   = av_c + AV_QSTEP;
		end
		if (ts_sum >= SEC_DIV) begin
			ts_r_n = CNT_W'(ts_sum - SEC_DIV);
			ts_n   = ts_c + TS_QSTEP + TEX_W'(1);
		end else begin
			ts_r_n = ts_sum[CNT_W-1:0];
			ts_n   = ts_c + TS_QSTEP;
		end
	end

	// Corner selection for the index records; the north cap has only the second triangle.
	always_comb begin
		corner_e = (stack_c == '0 && corner_c < CORNER_B0) ? CORNER_B0 : corner_c;
		k1 = K_W'(stack_c) * ROW_LEN + K_W'(sector_c);
		k2 = k1 + ROW_LEN;
		case (corner_e)
			CORNER_A0: corner_val = k1;
			CORNER_A1: corner_val = k2;
			CORNER_A2: corner_val = k1 + K_W'(1);
			CORNER_B0: corner_val = k1 + K_W'(1);
			CORNER_B1: corner_val = k2;
			default:   corner_val = k2 + K_W'(1);
		endcase
	end

	// Build the job and the next sequencer state.
	always_comb begin
		push_job             = '0;
		push_job.phase       = phase_c;
		phase_n              = phase_c;
		stack_n              = stack_c;
		sector_n             = sector_c;
		corner_n             = corner_c;
		if (phase_c == PHASE_VERTEX) begin
			push_job.angle_u = 32'h4000_0000 - au_c;
			push_job.angle_v = av_c;
			push_job.tex_s   = ts_c;
			push_job.tex_t   = tt_c;
			if (sector_c == SEC_MAX) begin
				sector_n = '0;
				if (stack_c == STK_MAX) begin
					stack_n  = '0;
					phase_n  = PHASE_INDEX;
					corner_n = '0;
				end else begin
					stack_n = stack_c + CNT_W'(1);
				end
			end else begin
				sector_n = sector_c + CNT_W'(1);
			end
		end else begin
			push_job.index_value = corner_val[IDX_W-1:0];
			corner_n = corner_e + 3'd1;
			if (corner_n == CORNER_B0 && stack_c == STK_LAST) begin
				corner_n = CORNER_END;
			end
			if (corner_n >= CORNER_END) begin
				corner_n = '0;
				if (sector_c == SEC_LAST) begin
					sector_n = '0;
					if (stack_c == STK_LAST) begin
						stack_n       = '0;
						phase_n       = PHASE_VERTEX;
						push_job.last = 1'b1;
					end else begin
						stack_n = stack_c + CNT_W'(1);
					end
				end else begin
					sector_n = sector_c + CNT_W'(1);
				end
			end
		end
	end

	// Sequencer registers, advanced on each transfer into the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PHASE_VERTEX;
			stack_q  <= '0;
			sector_q <= '0;
			corner_q <= '0;
			au_q     <= '0;
			av_q     <= '0;
			ts_q     <= '0;
			tt_q     <= '0;
			au_r_q   <= HALF_STK;
			tt_r_q   <= HALF_STK;
			av_r_q   <= HALF_SEC;
			ts_r_q   <= HALF_SEC;
		end else if (take) begin
			phase_q  <= phase_n;
			stack_q  <= stack_n;
			sector_q <= sector_n;
			corner_q <= corner_n;
			// Accumulators only move during the vertex pass and restart at each wrap.
			if (phase_c == PHASE_VERTEX) begin
				if (sector_c == SEC_MAX) begin
					av_q   <= '0;
					ts_q   <= '0;
					av_r_q <= HALF_SEC;
					ts_r_q <= HALF_SEC;
					if (stack_c == STK_MAX) begin
						au_q   <= '0;
						tt_q   <= '0;
						au_r_q <= HALF_STK;
						tt_r_q <= HALF_STK;
					end else begin
						au_q   <= au_n;
						tt_q   <= tt_n;
						au_r_q <= au_r_n;
						tt_r_q <= tt_r_n;
					end
				end else begin
					av_q   <= av_n;
					ts_q   <= ts_n;
					av_r_q <= av_r_n;
					ts_r_q <= ts_r_n;
					au_q   <= au_c;
					tt_q   <= tt_c;
					au_r_q <= au_r_c;
					tt_r_q <= tt_r_c;
				end
			end else begin
				au_q   <= au_c;
				av_q   <= av_c;
				ts_q   <= ts_c;
				tt_q   <= tt_c;
				au_r_q <= au_r_c;
				av_r_q <= av_r_c;
				ts_r_q <= ts_r_c;
				tt_r_q <= tt_r_c;
			end
		end
	end

endmodule

[rtl/uvs_queue.sv]
module uvs_queue import uvs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	job_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Two-entry job queue between the sequencer and the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

[rtl/uvs_back.sv]
module uvs_back import uvs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pop_valid,
	output logic                    pop_ready,
	input  job_t                    pop_job,
	input  logic [SCL_W-1:0]        max_scale,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    phase,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic [TEX_W-1:0]        tex_s,
	output logic [TEX_W-1:0]        tex_t,
	output logic signed [NRM_W-1:0] norm_x,
	output logic signed [NRM_W-1:0] norm_y,
	output logic signed [NRM_W-1:0] norm_z,
	output logic [IDX_W-1:0]        index_value,
	output logic                    last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_NRM  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

	logic [2:0]         state_q;
	logic [4:0]         step_q;
	logic signed [33:0] xu_q, yu_q, xv_q, yv_q;
	logic signed [32:0] zu_q, zv_q;
	logic [1:0]         quad_u_q, quad_v_q;
	logic [TEX_W-1:0]   tex_s_q, tex_t_q;
	logic signed [63:0] prod_x_q, prod_y_q;
	logic signed [33:0] nz_q;
	logic signed [NRM_W-1:0] nrm_x_q, nrm_y_q, nrm_z_q;
	logic signed [50:0] pp_x_q, pp_y_q, pp_z_q;

	logic               out_valid_q;
	logic               phase_q, last_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [TEX_W-1:0]   out_ts_q, out_tt_q;
	logic signed [NRM_W-1:0] out_nx_q, out_ny_q, out_nz_q;
	logic [IDX_W-1:0]   index_q;

	logic               slot_free;
	logic signed [32:0] atan_step;
	logic signed [33:0] dxu, dyu, dxv, dyv;
	logic signed [63:0] cs_u, cs_v;
	logic signed [31:0] cu, su, cv, sv;
	logic signed [33:0] nx, ny;
	logic signed [16:0] m_s;

	// Quadrant swap: packs cosine over sine.
	function automatic logic signed [63:0] quad_swap(input logic [1:0] quad,
			input logic signed [31:0] x, input logic signed [31:0] y);
		logic signed [63:0] r;
		case (quad)
			2'd0:    r = {x, y};
			2'd1:    r = {-y, x};
			2'd2:    r = {-x, -y};
			default: r = {y, -x};
		endcase
		return r;
	endfunction

	// Normal output: round to Q1.15 and saturate.
	function automatic logic signed [NRM_W-1:0] norm_round(input logic signed [33:0] n);
		logic signed [33:0] t;
		logic signed [NRM_W-1:0] r;
		t = (n + 34'sd16384) >>> 15;
		if (t > 34'sd32767) begin
			r = 16'sd32767;
		end else if (t < -34'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = t[NRM_W-1:0];
		end
		return r;
	endfunction

	// Position output: round the Q38 product to Q15 and saturate.
	function automatic logic signed [POS_W-1:0] pos_round(input logic signed [50:0] p);
		logic signed [50:0] t;
		logic signed [POS_W-1:0] r;
		t = (p + 51'sd4194304) >>> 23;
		if (t > 51'sd8388607) begin
			r = 24'sd8388607;
		end else if (t < -51'sd8388608) begin
			r = -24'sd8388608;
		end else begin
			r = t[POS_W-1:0];
		end
		return r;
	endfunction

	assign slot_free = !out_valid_q || out_ready;
	assign pop_ready = (state_q == ST_IDLE) &&
		(pop_job.phase == PHASE_VERTEX || slot_free);

	// Rotation step shared by both angle units.
	always_comb begin
		atan_step = signed'({3'b000, ATAN_TURNS[step_q]});
		dxu = yu_q >>> step_q;
		dyu = xu_q >>> step_q;
		dxv = yv_q >>> step_q;
		dyv = xv_q >>> step_q;
		cs_u = quad_swap(quad_u_q, xu_q[31:0], yu_q[31:0]);
		cs_v = quad_swap(quad_v_q, xv_q[31:0], yv_q[31:0]);
		cu = cs_u[63:32];
		su = cs_u[31:0];
		cv = cs_v[63:32];
		sv = cs_v[31:0];
		nx = 34'((prod_x_q + 64'sd536870912) >>> 30);
		ny = 34'((prod_y_q + 64'sd536870912) >>> 30);
		m_s = signed'({1'b0, max_scale});
	end

	// Datapath sequencer: rotate, multiply, round, write the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid && pop_ready) begin
						if (pop_job.phase == PHASE_INDEX) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_ROT;
							step_q  <= '0;
						end
					end
				end
				ST_ROT: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_MUL;
					end
					step_q <= step_q + 5'd1;
				end
				ST_MUL: state_q <= ST_NRM;
				ST_NRM: state_q <= ST_OUT;
				ST_OUT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid && pop_ready) begin
					if (pop_job.phase == PHASE_INDEX) begin
						phase_q  <= PHASE_INDEX;
						pos_x_q  <= '0;
						pos_y_q  <= '0;
						pos_z_q  <= '0;
						out_ts_q <= '0;
						out_tt_q <= '0;
						out_nx_q <= '0;
						out_ny_q <= '0;
						out_nz_q <= '0;
						index_q  <= pop_job.index_value;
						last_q   <= pop_job.last;
					end else begin
						xu_q     <= signed'({4'b0000, CORDIC_GAIN});
						xv_q     <= signed'({4'b0000, CORDIC_GAIN});
						yu_q     <= '0;
						yv_q     <= '0;
						zu_q     <= signed'({3'b000, pop_job.angle_u[29:0]});
						zv_q     <= signed'({3'b000, pop_job.angle_v[29:0]});
						quad_u_q <= pop_job.angle_u[31:30];
						quad_v_q <= pop_job.angle_v[31:30];
						tex_s_q  <= pop_job.tex_s;
						tex_t_q  <= pop_job.tex_t;
					end
				end
			end
			ST_ROT: begin
				if (!zu_q[32]) begin
					xu_q <= xu_q - dxu;
					yu_q <= yu_q + dyu;
					zu_q <= zu_q - atan_step;
				end else begin
					xu_q <= xu_q + dxu;
					yu_q <= yu_q - dyu;
					zu_q <= zu_q + atan_step;
				end
				if (!zv_q[32]) begin
					xv_q <= xv_q - dxv;
					yv_q <= yv_q + dyv;
					zv_q <= zv_q - atan_step;
				end else begin
					xv_q <= xv_q + dxv;
					yv_q <= yv_q - dyv;
					zv_q <= zv_q + atan_step;
				end
			end
			ST_MUL: begin
				prod_x_q <= cu * cv;
				prod_y_q <= cu * sv;
				nz_q     <= 34'(su);
			end
			ST_NRM: begin
				nrm_x_q <= norm_round(nx);
				nrm_y_q <= norm_round(ny);
				nrm_z_q <= norm_round(nz_q);
				pp_x_q  <= m_s * nx;
				pp_y_q  <= m_s * ny;
				pp_z_q  <= m_s * nz_q;
			end
			ST_OUT: begin
				if (slot_free) begin
					phase_q  <= PHASE_VERTEX;
					pos_x_q  <= pos_round(pp_x_q);
					pos_y_q  <= pos_round(pp_y_q);
					pos_z_q  <= pos_round(pp_z_q);
					out_ts_q <= tex_s_q;
					out_tt_q <= tex_t_q;
					out_nx_q <= nrm_x_q;
					out_ny_q <= nrm_y_q;
					out_nz_q <= nrm_z_q;
					index_q  <= '0;
					last_q   <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign phase       = phase_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign pos_z       = pos_z_q;
	assign tex_s       = out_ts_q;
	assign tex_t       = out_tt_q;
	assign norm_x      = out_nx_q;
	assign norm_y      = out_ny_q;
	assign norm_z      = out_nz_q;
	assign index_value = index_q;
	assign last        = last_q;

endmodule
